@@ sv/blsl_pkg.sv @@
// Boot image section loader: shared types and constants.
// Used by the parser, the result register and the top level.
`timescale 1ns / 1ps

package blsl_pkg;

  localparam int WORD_W  = 16;
  localparam int ADDR_W  = 32;
  localparam int KIND_W  = 2;
  localparam int ECODE_W = 2;
  localparam int CFG_INDEX_W = 8;

  // Configuration register indexes and reset values
  localparam logic [CFG_INDEX_W-1:0] CFG_HEADER_MAGIC = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PAD_VALUE    = 8'd1;
  localparam logic [WORD_W-1:0] MAGIC_RESET = 16'h09AA;
  localparam logic [WORD_W-1:0] PAD_RESET   = 16'h2020;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DONE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;

  // Error codes
  localparam logic [ECODE_W-1:0] ERR_MAGIC = 2'd0;
  localparam logic [ECODE_W-1:0] ERR_CFG   = 2'd1;
  localparam logic [ECODE_W-1:0] ERR_PAD   = 2'd2;

  // One result transaction
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [ADDR_W-1:0]  address;
    logic [WORD_W-1:0]  data;
    logic [ECODE_W-1:0] error_code;
  } result_t;

  // Parser output toward the result register
  typedef struct packed {
    logic    valid;
    result_t result;
  } emit_t;

endpackage

@@ sv/blsl_parser.sv @@
// Boot image parser: configuration registers, phase sequencer and
// per-word result generation. Depends on blsl_pkg.
`timescale 1ns / 1ps

module blsl_parser
  import blsl_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]      cfg_data,
  input  logic                   step,
  input  logic [WORD_W-1:0]      word,
  output emit_t                  emit
);

  localparam logic [3:0] PH_MAGIC    = 4'd0;
  localparam logic [3:0] PH_ENTRY_HI = 4'd1;
  localparam logic [3:0] PH_ENTRY_LO = 4'd2;
  localparam logic [3:0] PH_CFG      = 4'd3;
  localparam logic [3:0] PH_COUNT    = 4'd4;
  localparam logic [3:0] PH_LOAD_HI  = 4'd5;
  localparam logic [3:0] PH_LOAD_LO  = 4'd6;
  localparam logic [3:0] PH_DATA     = 4'd7;
  localparam logic [3:0] PH_PAD      = 4'd8;
  localparam logic [3:0] PH_HALT     = 4'd9;

  logic [WORD_W-1:0] header_magic;
  logic [WORD_W-1:0] pad_value;

  logic [3:0]        phase, phase_next;
  logic [WORD_W-1:0] high_half, high_half_next;
  logic [ADDR_W-1:0] entry_address, entry_address_next;
  logic [ADDR_W-1:0] load_address, load_address_next;
  logic [WORD_W-1:0] words_left, words_left_next;
  logic [1:0]        pads_left, pads_left_next;

  logic [WORD_W-1:0] words_dec;
  logic [1:0]        pads_dec;

  assign words_dec = words_left - 16'd1;
  assign pads_dec  = pads_left - 2'd1;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      header_magic <= MAGIC_RESET;
      pad_value    <= PAD_RESET;
    end else if (cfg_write) begin
      if (cfg_index == CFG_HEADER_MAGIC) begin
        header_magic <= cfg_data;
      end else if (cfg_index == CFG_PAD_VALUE) begin
        pad_value <= cfg_data;
      end
    end
  end

  // Next state and result for the current word
  always_comb begin
    phase_next         = phase;
    high_half_next     = high_half;
    entry_address_next = entry_address;
    load_address_next  = load_address;
    words_left_next    = words_left;
    pads_left_next     = pads_left;
    emit               = '0;
    case (phase)
      PH_MAGIC: begin
        if (word != header_magic) begin
          phase_next = PH_HALT;
          emit.valid = 1'b1;
          emit.result.kind = KIND_ERROR;
          emit.result.error_code = ERR_MAGIC;
        end else begin
          phase_next = PH_ENTRY_HI;
        end
      end
      PH_ENTRY_HI: begin
        high_half_next = word;
        phase_next     = PH_ENTRY_LO;
      end
      PH_ENTRY_LO: begin
        entry_address_next = {high_half, word};
        phase_next         = PH_CFG;
      end
      PH_CFG: begin
        if (word != '0) begin
          phase_next = PH_HALT;
          emit.valid = 1'b1;
          emit.result.kind = KIND_ERROR;
          emit.result.error_code = ERR_CFG;
        end else begin
          phase_next = PH_COUNT;
        end
      end
      PH_COUNT: begin
        if (word == '0) begin
          phase_next = PH_HALT;
          emit.valid = 1'b1;
          emit.result.kind = KIND_DONE;
          emit.result.address = entry_address;
        end else begin
          words_left_next = word;
          // pads = (4 - (count + 2) % 4) % 4, i.e. (2 - count) mod 4
          pads_left_next  = 2'd2 - word[1:0];
          phase_next      = PH_LOAD_HI;
        end
      end
      PH_LOAD_HI: begin
        high_half_next = word;
        phase_next     = PH_LOAD_LO;
      end
      PH_LOAD_LO: begin
        load_address_next = {high_half, word};
        if (words_left != '0) begin
          phase_next = PH_DATA;
        end else if (pads_left != '0) begin
          phase_next = PH_PAD;
        end else begin
          phase_next = PH_COUNT;
        end
      end
      PH_DATA: begin
        emit.valid = 1'b1;
        emit.result.kind = KIND_WRITE;
        emit.result.address = load_address;
        emit.result.data = word;
        load_address_next = load_address + 32'd1;
        words_left_next   = words_dec;
        if (words_dec == '0) begin
          phase_next = (pads_left != '0) ? PH_PAD : PH_COUNT;
        end
      end
      PH_PAD: begin
        if (word != pad_value) begin
          phase_next = PH_HALT;
          emit.valid = 1'b1;
          emit.result.kind = KIND_ERROR;
          emit.result.error_code = ERR_PAD;
        end else begin
          pads_left_next = pads_dec;
          if (pads_dec == '0) begin
            phase_next = PH_COUNT;
          end
        end
      end
      default: begin
        phase_next = PH_HALT;
      end
    endcase
  end

  // State update on each processed word
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_MAGIC;
      high_half     <= '0;
      entry_address <= '0;
      load_address  <= '0;
      words_left    <= '0;
      pads_left     <= '0;
    end else if (step) begin
      phase         <= phase_next;
      high_half     <= high_half_next;
      entry_address <= entry_address_next;
      load_address  <= load_address_next;
      words_left    <= words_left_next;
      pads_left     <= pads_left_next;
    end
  end

  // Halt is sticky until reset
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    phase == PH_HALT |=> phase == PH_HALT)
    else $error("parser left halt without reset");

  // Done is only produced at a section count
  a_done_from_count: assert property (@(posedge clk) disable iff (rst)
    emit.valid && emit.result.kind == KIND_DONE |-> phase == PH_COUNT)
    else $error("done emitted outside count phase");

  // Any error or done moves the parser to halt
  a_end_halts: assert property (@(posedge clk) disable iff (rst)
    step && emit.valid && emit.result.kind != KIND_WRITE |=> phase == PH_HALT)
    else $error("error or done did not halt the parser");

endmodule

@@ sv/blsl_out_reg.sv @@
// Result register holding one transaction until the consumer takes it.
// Depends on blsl_pkg.
`timescale 1ns / 1ps

module blsl_out_reg
  import blsl_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t load_result,
  input  logic    stall,
  output logic    valid,
  output result_t result
);

  logic valid_r;

  // Valid flag: set on load, cleared when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (!stall) begin
      valid_r <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (load) begin
      result <= load_result;
    end
  end

  assign valid = valid_r;

endmodule

@@ sv/boot_image_section_loader_core.sv @@
// Top level of the boot image section loader.
// Depends on blsl_pkg, blsl_parser and blsl_out_reg.
`timescale 1ns / 1ps

// The loader takes one 16-bit image word per cycle and gives at most one
// result per word: a memory write for each data word, done with the entry
// address, or an error (bad magic, nonzero configuration count, bad pad).
// A word is registered on acceptance, decoded in the next cycle against the
// phase sequencer, and its result lands in the output register when that
// register can take it. The input stalls only while both the word register
// and the output register are full and the output is stalled. After done or
// an error every word is taken and dropped until reset. Configuration writes
// belong to idle periods.

module boot_image_section_loader_core
  import blsl_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]      cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [WORD_W-1:0]      word,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [KIND_W-1:0]      kind,
  output logic [ADDR_W-1:0]      address,
  output logic [WORD_W-1:0]      data,
  output logic [ECODE_W-1:0]     error_code
);

  logic              word_valid;
  logic [WORD_W-1:0] word_r;
  logic              step;
  emit_t             emit;
  result_t           result;

  // Word register advances whenever the output register can take a result
  assign step     = word_valid && !(out_valid && out_stall);
  assign in_stall = word_valid && !step;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (!in_stall) begin
      word_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      word_r <= word;
    end
  end

  blsl_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (step),
    .word      (word_r),
    .emit      (emit)
  );

  blsl_out_reg u_out_reg (
    .clk         (clk),
    .rst         (rst),
    .load        (step && emit.valid),
    .load_result (emit.result),
    .stall       (out_stall),
    .valid       (out_valid),
    .result      (result)
  );

  assign kind       = result.kind;
  assign address    = result.address;
  assign data       = result.data;
  assign error_code = result.error_code;

endmodule
